/* sv/rdmv_pkg.sv */
// Shared types, widths and constants for the radial distortion mesh vertex block.
// No dependencies; imported by every module of the block.
package rdmv_pkg;

  localparam int GRID_COLUMNS_DEF = 32;
  localparam int GRID_ROWS_DEF    = 32;
  localparam int NUM_COLORS       = 3;

  // Port widths
  localparam int IDX_W      = 6;
  localparam int SIZE_W     = 13;
  localparam int CENTER_W   = 21;
  localparam int COEF_W     = 26;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Datapath widths (coordinates carry 8 fraction bits)
  localparam int FRAC_W     = 8;
  localparam int SCALE_W    = SIZE_W + IDX_W;
  localparam int NUM_W      = SCALE_W + FRAC_W;
  localparam int HALF_W     = SIZE_W + FRAC_W - 1;
  localparam int COORD_W    = 29;
  localparam int MAG_W      = COORD_W - 1;
  localparam int R2_W       = 2 * MAG_W + 1;
  localparam int DR_W       = MAG_W + R2_W;
  localparam int PROD_W     = DR_W + COEF_W;
  localparam int TERM_SHIFT = 40;
  localparam int SCALED_W   = PROD_W - TERM_SHIFT;

  // Radial term divider: quotients at or above 2^Q_BITS saturate the output unless the viewport size is zero
  localparam int Q_BITS     = 35;
  localparam int DIV_STEP   = 5;
  localparam int DIV_STAGES = Q_BITS / DIV_STEP;

  localparam int FRONT_LAT  = 8;
  localparam int TERM_LAT   = DIV_STAGES + 4;
  localparam int PIPE_LAT   = FRONT_LAT + TERM_LAT;

  localparam logic [SIZE_W-1:0] VIEW_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] VIEW_HEIGHT_RST = 13'd480;
  localparam logic [COEF_W-1:0] COEF_MAG_RST    = 26'd8389;
  localparam logic              COEF_NEG_RST    = 1'b1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_WIDTH,
    CFG_VIEW_HEIGHT,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_COEFF_RED,
    CFG_COEFF_GREEN,
    CFG_COEFF_BLUE
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0]          view_width;
    logic [SIZE_W-1:0]          view_height;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
  } geom_cfg_t;

  typedef struct packed {
    logic              neg;
    logic [COEF_W-1:0] mag;
  } coef_t;

  // One axis leaving the grid front end: ideal position and |offset| * r^2
  typedef struct packed {
    logic signed [COORD_W-1:0] pos;
    logic [DR_W-1:0]           dmag;
    logic                      dneg;
  } axis_t;

endpackage

/* sv/rdmv_grid.sv */
// Front end: grid index to ideal position, center offset, r^2 and |offset| * r^2.
// Eight register stages, both axes side by side. Depends on rdmv_pkg.
module rdmv_grid #(
  parameter int GRID_COLUMNS = rdmv_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = rdmv_pkg::GRID_ROWS_DEF
) (
  input  logic                         clk,
  input  logic [rdmv_pkg::IDX_W-1:0]   grid_column,
  input  logic [rdmv_pkg::IDX_W-1:0]   grid_row,
  input  rdmv_pkg::geom_cfg_t          geom,
  output rdmv_pkg::axis_t              axis_x,
  output rdmv_pkg::axis_t              axis_y
);
  import rdmv_pkg::*;

  // floor(n / d) = (n * m) >> (NUM_W + l) for n < 2^NUM_W, m = ceil(2^(NUM_W+l) / d)
  localparam int X_SH = NUM_W + $clog2(GRID_COLUMNS);
  localparam int Y_SH = NUM_W + $clog2(GRID_ROWS);
  localparam logic [63:0] X_RECIP = ((64'd1 << X_SH) + GRID_COLUMNS - 1) / GRID_COLUMNS;
  localparam logic [63:0] Y_RECIP = ((64'd1 << Y_SH) + GRID_ROWS - 1) / GRID_ROWS;
  localparam int          SHIFT [2] = '{X_SH, Y_SH};
  localparam logic [63:0] RECIP [2] = '{X_RECIP, Y_RECIP};

  localparam int SQ_W     = 2 * MAG_W;
  localparam int R2_LO_W  = MAG_W + 1;
  localparam int R2_HI_W  = R2_W - R2_LO_W;
  localparam int PLO_W    = MAG_W + R2_LO_W;
  localparam int PHI_W    = MAG_W + R2_HI_W;

  logic [IDX_W-1:0]           idx  [2];
  logic [SIZE_W-1:0]          size [2];
  logic signed [CENTER_W-1:0] ctr  [2];

  logic [SCALE_W-1:0]        nx1_r  [2];
  logic [63:0]               prod_w [2];
  logic [NUM_W-1:0]          qx2_r  [2];
  logic signed [COORD_W-1:0] pos3_nxt [2];
  logic signed [COORD_W-1:0] off3_nxt [2];
  logic signed [COORD_W-1:0] pos3_r [2];
  logic signed [COORD_W-1:0] off3_r [2];
  logic signed [COORD_W-1:0] pos4_r [2];
  logic [MAG_W-1:0]          mag4_r [2];
  logic                      neg4_r [2];
  logic signed [COORD_W-1:0] pos5_r [2];
  logic [MAG_W-1:0]          mag5_r [2];
  logic                      neg5_r [2];
  logic [SQ_W-1:0]           sq5_r  [2];
  logic signed [COORD_W-1:0] pos6_r [2];
  logic [MAG_W-1:0]          mag6_r [2];
  logic                      neg6_r [2];
  logic [R2_W-1:0]           r2_6_r;
  logic signed [COORD_W-1:0] pos7_r [2];
  logic                      neg7_r [2];
  logic [PLO_W-1:0]          plo7_r [2];
  logic [PHI_W-1:0]          phi7_r [2];
  axis_t                     axis8_r [2];

  assign idx[0]  = grid_column;
  assign idx[1]  = grid_row;
  assign size[0] = geom.view_width;
  assign size[1] = geom.view_height;
  assign ctr[0]  = geom.center_x;
  assign ctr[1]  = geom.center_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      prod_w[a] = {{(64-NUM_W){1'b0}}, nx1_r[a], {FRAC_W{1'b0}}} * RECIP[a];
      // x = floor(size*idx*256/grid) - size*128
      pos3_nxt[a] = $signed({{(COORD_W-NUM_W){1'b0}}, qx2_r[a]})
                  - $signed({{(COORD_W-HALF_W){1'b0}}, size[a], {(FRAC_W-1){1'b0}}});
      off3_nxt[a] = pos3_nxt[a]
                  - $signed({{(COORD_W-CENTER_W){ctr[a][CENTER_W-1]}}, ctr[a]});
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      nx1_r[a]  <= {{IDX_W{1'b0}}, size[a]} * {{SIZE_W{1'b0}}, idx[a]};
      qx2_r[a]  <= prod_w[a][SHIFT[a] +: NUM_W];
      pos3_r[a] <= pos3_nxt[a];
      off3_r[a] <= off3_nxt[a];

      pos4_r[a] <= pos3_r[a];
      neg4_r[a] <= off3_r[a][COORD_W-1];
      mag4_r[a] <= off3_r[a][COORD_W-1] ? MAG_W'(-off3_r[a]) : MAG_W'(off3_r[a]);

      pos5_r[a] <= pos4_r[a];
      neg5_r[a] <= neg4_r[a];
      mag5_r[a] <= mag4_r[a];
      sq5_r[a]  <= SQ_W'(mag4_r[a]) * SQ_W'(mag4_r[a]);

      pos6_r[a] <= pos5_r[a];
      neg6_r[a] <= neg5_r[a];
      mag6_r[a] <= mag5_r[a];

      pos7_r[a] <= pos6_r[a];
      neg7_r[a] <= neg6_r[a];
      plo7_r[a] <= PLO_W'(mag6_r[a]) * PLO_W'(r2_6_r[R2_LO_W-1:0]);
      phi7_r[a] <= PHI_W'(mag6_r[a]) * PHI_W'(r2_6_r[R2_W-1:R2_LO_W]);

      axis8_r[a].pos  <= pos7_r[a];
      axis8_r[a].dneg <= neg7_r[a];
      axis8_r[a].dmag <= DR_W'(plo7_r[a]) + {phi7_r[a], {R2_LO_W{1'b0}}};
    end
    r2_6_r <= R2_W'(sq5_r[0]) + R2_W'(sq5_r[1]);
  end

  assign axis_x = axis8_r[0];
  assign axis_y = axis8_r[1];

endmodule

/* sv/rdmv_term.sv */
// One warped coordinate: coefficient product, scaling by 2^-40, pipelined
// restoring divide by the viewport size, add to the ideal position, saturate.
// Depends on rdmv_pkg.
module rdmv_term (
  input  logic                         clk,
  input  rdmv_pkg::axis_t              axis_in,
  input  rdmv_pkg::coef_t              coef,
  input  logic [rdmv_pkg::SIZE_W-1:0]  size,
  output logic [rdmv_pkg::OUT_W-1:0]   result
);
  import rdmv_pkg::*;

  localparam int CHUNK_W  = 29;
  localparam int CHUNK2_W = DR_W - 2 * CHUNK_W;
  localparam int PP_W     = COEF_W + CHUNK_W;
  localparam int PP2_W    = COEF_W + CHUNK2_W;
  localparam int SUM_W    = Q_BITS + 2;

  logic [PP_W-1:0]           pp0_r, pp1_r;
  logic [PP2_W-1:0]          pp2_r;
  logic signed [COORD_W-1:0] pos1_r, pos2_r;
  logic                      neg1_r, neg2_r;
  logic [PROD_W-1:0]         sum_w;
  logic [SCALED_W-1:0]       scaled2_r;

  // divider stage registers, index 0 is the stage that loads the dividend
  logic [SIZE_W-1:0]         rem_r  [DIV_STAGES+1];
  logic [Q_BITS-1:0]         bits_r [DIV_STAGES+1];
  logic [Q_BITS-1:0]         quo_r  [DIV_STAGES+1];
  logic signed [COORD_W-1:0] pos_r  [DIV_STAGES+1];
  logic                      neg_r  [DIV_STAGES+1];
  logic                      ovf_r  [DIV_STAGES+1];
  logic                      zero_r [DIV_STAGES+1];
  logic [SIZE_W-1:0]         rem_nxt  [DIV_STAGES];
  logic [Q_BITS-1:0]         bits_nxt [DIV_STAGES];
  logic [Q_BITS-1:0]         quo_nxt  [DIV_STAGES];

  logic [SUM_W-1:0]          quo_ext;
  logic [SUM_W-1:0]          add_w;
  logic                      fits_w;
  logic [OUT_W-1:0]          result_nxt;
  logic [OUT_W-1:0]          result_r;

  assign sum_w = {{(PROD_W-PP_W){1'b0}}, pp0_r}
               + {{(PROD_W-PP_W-CHUNK_W){1'b0}}, pp1_r, {CHUNK_W{1'b0}}}
               + {pp2_r, {(2*CHUNK_W){1'b0}}};

  always_comb begin
    logic [SIZE_W-1:0] rem_w;
    logic [Q_BITS-1:0] bits_w;
    logic [Q_BITS-1:0] quo_w;
    logic [SIZE_W:0]   trial_w;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_w  = rem_r[s];
      bits_w = bits_r[s];
      quo_w  = quo_r[s];
      for (int j = 0; j < DIV_STEP; j++) begin
        trial_w = {rem_w, bits_w[Q_BITS-1]};
        bits_w  = {bits_w[Q_BITS-2:0], 1'b0};
        if (trial_w >= {1'b0, size}) begin
          trial_w = trial_w - {1'b0, size};
          quo_w   = {quo_w[Q_BITS-2:0], 1'b1};
        end else begin
          quo_w   = {quo_w[Q_BITS-2:0], 1'b0};
        end
        rem_w = trial_w[SIZE_W-1:0];
      end
      rem_nxt[s]  = rem_w;
      bits_nxt[s] = bits_w;
      quo_nxt[s]  = quo_w;
    end
  end

  always_comb begin
    quo_ext = {2'b00, quo_r[DIV_STAGES]};
    add_w   = {{(SUM_W-COORD_W){pos_r[DIV_STAGES][COORD_W-1]}}, pos_r[DIV_STAGES]}
            + (neg_r[DIV_STAGES] ? (~quo_ext + SUM_W'(1)) : quo_ext);
    fits_w  = (&add_w[SUM_W-1:OUT_W-1]) || !(|add_w[SUM_W-1:OUT_W-1]);
    if (zero_r[DIV_STAGES]) begin
      // zero viewport size: no radial term
      result_nxt = {{(OUT_W-COORD_W){pos_r[DIV_STAGES][COORD_W-1]}}, pos_r[DIV_STAGES]};
    end else if (ovf_r[DIV_STAGES]) begin
      result_nxt = neg_r[DIV_STAGES] ? SAT_MIN : SAT_MAX;
    end else if (fits_w) begin
      result_nxt = add_w[OUT_W-1:0];
    end else begin
      result_nxt = add_w[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    pp0_r  <= PP_W'(coef.mag) * PP_W'(axis_in.dmag[CHUNK_W-1:0]);
    pp1_r  <= PP_W'(coef.mag) * PP_W'(axis_in.dmag[2*CHUNK_W-1:CHUNK_W]);
    pp2_r  <= PP2_W'(coef.mag) * PP2_W'(axis_in.dmag[DR_W-1:2*CHUNK_W]);
    pos1_r <= axis_in.pos;
    neg1_r <= coef.neg ^ axis_in.dneg;

    scaled2_r <= sum_w[PROD_W-1:TERM_SHIFT];
    pos2_r    <= pos1_r;
    neg2_r    <= neg1_r;

    // quotient >= 2^Q_BITS when the top part of the dividend already reaches size
    ovf_r[0]  <= (|scaled2_r[SCALED_W-1:SIZE_W+Q_BITS])
              || (scaled2_r[SIZE_W+Q_BITS-1:Q_BITS] >= size);
    zero_r[0] <= (size == '0);
    rem_r[0]  <= scaled2_r[SIZE_W+Q_BITS-1:Q_BITS];
    bits_r[0] <= scaled2_r[Q_BITS-1:0];
    quo_r[0]  <= '0;
    pos_r[0]  <= pos2_r;
    neg_r[0]  <= neg2_r;

    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_r[s+1]  <= rem_nxt[s];
      bits_r[s+1] <= bits_nxt[s];
      quo_r[s+1]  <= quo_nxt[s];
      pos_r[s+1]  <= pos_r[s];
      neg_r[s+1]  <= neg_r[s];
      ovf_r[s+1]  <= ovf_r[s];
      zero_r[s+1] <= zero_r[s];
    end

    result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

/* sv/radial_distortion_mesh_vertex.sv */
// Each accepted vertex shows its result strobed by out_valid for one cycle.
// Throughput: one vertex per cycle while busy is low.
// Depth is set by the 35-bit radial divide, 5 quotient bits per stage, behind
// an 8-stage front end. Reset (synchronous, rst_n low) empties the pipeline,
// loads the register defaults and holds busy high until the cycle after release.
// The receiver cannot stall; results are never held back.
module radial_distortion_mesh_vertex #(
  parameter int GRID_COLUMNS = rdmv_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = rdmv_pkg::GRID_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rdmv_pkg::IDX_W-1:0]       in_grid_column,
  input  logic [rdmv_pkg::IDX_W-1:0]       in_grid_row,
  output logic                             out_valid,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_red_x,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_red_y,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_green_x,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_green_y,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_blue_x,
  output logic signed [rdmv_pkg::OUT_W-1:0] out_blue_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rdmv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdmv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rdmv_pkg::*;

  logic                  busy_r;
  logic                  accept;
  logic [PIPE_LAT-1:0]   vld_r, vld_nxt;

  geom_cfg_t             geom_r, geom_nxt;
  coef_t                 coef_r   [NUM_COLORS];
  coef_t                 coef_nxt [NUM_COLORS];

  axis_t                 axis_x, axis_y;
  logic [OUT_W-1:0]      res [2*NUM_COLORS];

  function automatic coef_t to_coef(input logic [COEF_W-1:0] raw);
    coef_t c;
    c.neg = raw[COEF_W-1];
    c.mag = raw[COEF_W-1] ? (~raw + COEF_W'(1)) : raw;
    return c;
  endfunction

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign vld_nxt   = {vld_r[PIPE_LAT-2:0], accept};
  assign out_valid = vld_r[PIPE_LAT-1];

  always_comb begin
    geom_nxt = geom_r;
    coef_nxt = coef_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VIEW_WIDTH:  geom_nxt.view_width  = cfg_wdata[SIZE_W-1:0];
        CFG_VIEW_HEIGHT: geom_nxt.view_height = cfg_wdata[SIZE_W-1:0];
        CFG_CENTER_X:    geom_nxt.center_x    = cfg_wdata[CENTER_W-1:0];
        CFG_CENTER_Y:    geom_nxt.center_y    = cfg_wdata[CENTER_W-1:0];
        CFG_COEFF_RED:   coef_nxt[0]          = to_coef(cfg_wdata[COEF_W-1:0]);
        CFG_COEFF_GREEN: coef_nxt[1]          = to_coef(cfg_wdata[COEF_W-1:0]);
        CFG_COEFF_BLUE:  coef_nxt[2]          = to_coef(cfg_wdata[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r             <= 1'b1;
      vld_r              <= '0;
      geom_r.view_width  <= VIEW_WIDTH_RST;
      geom_r.view_height <= VIEW_HEIGHT_RST;
      geom_r.center_x    <= '0;
      geom_r.center_y    <= '0;
      for (int c = 0; c < NUM_COLORS; c++) begin
        coef_r[c].neg <= COEF_NEG_RST;
        coef_r[c].mag <= COEF_MAG_RST;
      end
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
      geom_r <= geom_nxt;
      coef_r <= coef_nxt;
    end
  end

  rdmv_grid #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_grid (
    .clk         (clk),
    .grid_column (in_grid_column),
    .grid_row    (in_grid_row),
    .geom        (geom_r),
    .axis_x      (axis_x),
    .axis_y      (axis_y)
  );

  for (genvar c = 0; c < NUM_COLORS; c++) begin : g_color
    rdmv_term u_term_x (
      .clk     (clk),
      .axis_in (axis_x),
      .coef    (coef_r[c]),
      .size    (geom_r.view_width),
      .result  (res[2*c])
    );
    rdmv_term u_term_y (
      .clk     (clk),
      .axis_in (axis_y),
      .coef    (coef_r[c]),
      .size    (geom_r.view_height),
      .result  (res[2*c+1])
    );
  end

  assign out_red_x   = $signed(res[0]);
  assign out_red_y   = $signed(res[1]);
  assign out_green_x = $signed(res[2]);
  assign out_green_y = $signed(res[3]);
  assign out_blue_x  = $signed(res[4]);
  assign out_blue_y  = $signed(res[5]);

endmodule

/* sv/rdmv_checker.sv */
// Port-level checks for radial_distortion_mesh_vertex, attached by bind.
// Depends on rdmv_pkg for the pipeline latency.
module rdmv_sva (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import rdmv_pkg::*;

  a_busy_in_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after a reset cycle");

  a_free_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset recovery");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching transaction");

  a_every_item_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted transaction produced no result");

endmodule

bind radial_distortion_mesh_vertex rdmv_sva u_rdmv_sva (.*);
